// File: sv/btm_pkg.sv
// Shared types and constants of the binary trie multiset.
// No dependencies; every other source file but btm_ram imports this package.
package btm_pkg;

  localparam int unsigned KEY_BITS_DEF   = 12;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CNT_W          = 16;
  localparam int unsigned RANK_W         = 16;
  localparam int unsigned DEPTH_W        = 4;

  typedef enum logic [2:0] {
    CMD_INSERT     = 3'd0,
    CMD_ERASE      = 3'd1,
    CMD_XOR_MIN    = 3'd2,
    CMD_XOR_MAX    = 3'd3,
    CMD_KTH        = 3'd4,
    CMD_CNT_BELOW  = 3'd5,
    CMD_CNT_ATMOST = 3'd6,
    CMD_PREFIX     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_ABSENT = 3'd2,
    STAT_RANGE  = 3'd3,
    STAT_FULL   = 3'd4
  } stat_e;

  // Walk token control: dec marks the decrement pass of an erase.
  typedef struct packed {
    logic valid;
    cmd_e cmd;
    logic dec;
  } btm_ctl_t;

endpackage

// File: sv/btm_in_if.sv
// Command channel: valid/ready plus the command fields.
// Depends on btm_pkg.
interface btm_in_if import btm_pkg::*; #(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  cmd_e                cmd;
  logic [KEY_BITS-1:0] key;
  logic [RANK_W-1:0]   rank_index;
  logic [DEPTH_W-1:0]  prefix_depth;

  modport source (output valid, cmd, key, rank_index, prefix_depth, input ready);
  modport sink   (input valid, cmd, key, rank_index, prefix_depth, output ready);
endinterface

// File: sv/btm_out_if.sv
// Result channel: valid/ready plus the result fields.
// Depends on btm_pkg.
interface btm_out_if import btm_pkg::*; #(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] found_key;
  logic [CNT_W-1:0]    count_value;
  logic [CNT_W-1:0]    set_size;
  stat_e               status;

  modport source (output valid, found_key, count_value, set_size, status, input ready);
  modport sink   (input valid, found_key, count_value, set_size, status, output ready);
endinterface

// File: sv/btm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module btm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/btm_cell.sv
// One trie level: count RAM of that level and the step of the walk on it.
// Depends on btm_pkg and btm_ram.
module btm_cell import btm_pkg::*; #(
  parameter int unsigned LEVEL      = 1,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned DW        = $clog2(KEY_BITS + 1),
  localparam int unsigned B         = KEY_BITS - LEVEL
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic [KEY_BITS-1:0]   clr_addr_i,
  input  btm_ctl_t              ctl_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [KEY_BITS-1:0]   path_i,
  input  logic [COUNT_BITS-1:0] k_i,
  input  logic [COUNT_BITS-1:0] tot_i,
  input  logic [DW-1:0]         depth_i,
  output btm_ctl_t              ctl_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [KEY_BITS-1:0]   path_o,
  output logic [COUNT_BITS-1:0] k_o,
  output logic [COUNT_BITS-1:0] tot_o,
  output logic [DW-1:0]         depth_o
);
  btm_ctl_t              ctl_q;
  logic [KEY_BITS-1:0]   key_q, path_q, path_d;
  logic [COUNT_BITS-1:0] k_q, tot_q, rdata;
  logic [DW-1:0]         depth_q;
  logic                  abit, bit_sel, lt, we;
  logic [LEVEL-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;

  // address phase: left child for rank walks, key bit otherwise
  always_comb begin
    unique case (ctl_i.cmd)
      CMD_KTH, CMD_CNT_BELOW, CMD_CNT_ATMOST: abit = 1'b0;
      default:                                abit = key_i[B];
    endcase
    path_d    = path_i;
    path_d[B] = abit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_i;
    path_q  <= path_d;
    k_q     <= k_i;
    tot_q   <= tot_i;
    depth_q <= depth_i;
  end

  // decision phase on the count just read
  always_comb begin
    lt      = k_q < rdata;
    bit_sel = key_q[B];
    k_o     = k_q;
    tot_o   = tot_q;
    unique case (ctl_q.cmd)
      CMD_XOR_MIN, CMD_XOR_MAX: bit_sel = (rdata == '0) ? ~key_q[B] : key_q[B];
      CMD_KTH: begin
        bit_sel = ~lt;
        if (!lt) begin
          k_o = k_q - rdata;
        end
      end
      CMD_CNT_BELOW, CMD_CNT_ATMOST: begin
        if (key_q[B]) begin
          tot_o = tot_q + rdata;
        end
      end
      CMD_PREFIX: begin
        if (depth_q == DW'(LEVEL)) begin
          tot_o = rdata;
        end
      end
      CMD_ERASE: begin
        if (LEVEL == KEY_BITS && !ctl_q.dec) begin
          tot_o = rdata;
        end
      end
      default: ;
    endcase
    path_o    = path_q;
    path_o[B] = bit_sel;
  end

  assign ctl_o   = ctl_q;
  assign key_o   = key_q;
  assign depth_o = depth_q;

  always_comb begin
    we    = clr_i;
    waddr = clr_addr_i[LEVEL-1:0];
    wdata = '0;
    if (!clr_i && ctl_q.valid) begin
      waddr = path_q[KEY_BITS-1 -: LEVEL];
      if (ctl_q.cmd == CMD_INSERT) begin
        we    = 1'b1;
        wdata = rdata + COUNT_BITS'(1);
      end else if (ctl_q.cmd == CMD_ERASE && ctl_q.dec) begin
        we    = 1'b1;
        wdata = rdata - COUNT_BITS'(1);
      end
    end
  end

  btm_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(2 ** LEVEL)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(path_d[KEY_BITS-1 -: LEVEL]),
    .rdata_o(rdata)
  );
endmodule

// File: sv/binary_trie_multiset.sv
// Multiset of KEY_BITS-wide keys kept as a binary trie of occurrence counts,
// one cell (with its own count RAM) per trie level and the root count in a register.
// After reset the block clears its RAMs before the first command transfer. A
// command then walks the chain one level per cycle, one RAM read (and for
// insert/erase one write) per cell; an erase of a present key takes a second
// walk, and commands answered from the root count alone (a full set, an empty
// set, a rank out of range, count at most the largest key, prefix depth 0) come
// out the next cycle. One command is in flight at a time; a held result blocks
// the next command transfer until the cycle in which it is taken. Depends on
// btm_pkg, the interfaces, btm_cell.
module binary_trie_multiset import btm_pkg::*; #(
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  btm_in_if.sink    in_i,
  btm_out_if.source out_o
);
  localparam int unsigned DW = $clog2(KEY_BITS + 1);
  localparam int unsigned W  = (COUNT_BITS > RANK_W) ? COUNT_BITS : RANK_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [KEY_BITS-1:0]   clr_q;
  logic [COUNT_BITS-1:0] size_q, size_d;
  logic [KEY_BITS-1:0]   ekey_q, ekey;
  logic                  ov_q, ov_d;
  logic [KEY_BITS-1:0]   found_q, found_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  stat_e                 stat_q, stat_d;

  btm_ctl_t              ctl_c   [KEY_BITS+1];
  logic [KEY_BITS-1:0]   key_c   [KEY_BITS+1];
  logic [KEY_BITS-1:0]   path_c  [KEY_BITS+1];
  logic [COUNT_BITS-1:0] k_c     [KEY_BITS+1];
  logic [COUNT_BITS-1:0] tot_c   [KEY_BITS+1];
  logic [DW-1:0]         depth_c [KEY_BITS+1];

  logic          acc, walk, dec_launch;
  logic [DW-1:0] dclamp;
  btm_ctl_t      last;
  logic [W-1:0]  cnt_w, size_w;

  assign in_i.ready = (state_q == S_IDLE) && (!ov_q || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;
  assign last       = ctl_c[KEY_BITS];
  assign dec_launch = (state_q == S_WALK) && last.valid && last.cmd == CMD_ERASE
                      && !last.dec && tot_c[KEY_BITS] != '0;

  always_comb begin
    unique case (in_i.cmd)
      CMD_XOR_MAX:    ekey = ~in_i.key;
      CMD_CNT_ATMOST: ekey = in_i.key + KEY_BITS'(1);
      default:        ekey = in_i.key;
    endcase
    if (32'(in_i.prefix_depth) > KEY_BITS) begin
      dclamp = DW'(KEY_BITS);
    end else begin
      dclamp = DW'(in_i.prefix_depth);
    end
  end

  // control: launch, early answers, end of walk
  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    ov_d    = ov_q && !out_o.ready;
    found_d = found_q;
    cnt_d   = cnt_q;
    stat_d  = stat_q;
    walk    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          found_d = '0;
          cnt_d   = '0;
          stat_d  = STAT_OK;
          ov_d    = 1'b1;
          priority if (in_i.cmd == CMD_INSERT) begin
            if (&size_q) begin
              stat_d = STAT_FULL;
            end else begin
              walk   = 1'b1;
              size_d = size_q + COUNT_BITS'(1);
            end
          end else if (size_q == '0) begin
            stat_d = STAT_EMPTY;
          end else if (in_i.cmd == CMD_KTH && W'(in_i.rank_index) >= W'(size_q)) begin
            stat_d = STAT_RANGE;
          end else if (in_i.cmd == CMD_CNT_ATMOST && (&in_i.key)) begin
            cnt_d = size_q;
          end else if (in_i.cmd == CMD_PREFIX && dclamp == '0) begin
            cnt_d = size_q;
          end else begin
            walk = 1'b1;
          end
          if (walk) begin
            ov_d    = 1'b0;
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (last.valid) begin
          if (dec_launch) begin
            size_d = size_q - COUNT_BITS'(1);
          end else begin
            state_d = S_IDLE;
            ov_d    = 1'b1;
            found_d = '0;
            cnt_d   = '0;
            stat_d  = STAT_OK;
            unique case (last.cmd)
              CMD_XOR_MIN, CMD_XOR_MAX, CMD_KTH: found_d = path_c[KEY_BITS];
              CMD_CNT_BELOW, CMD_CNT_ATMOST, CMD_PREFIX: cnt_d = tot_c[KEY_BITS];
              CMD_ERASE: begin
                if (!last.dec) begin
                  stat_d = STAT_ABSENT;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    path_c[0] = '0;
    tot_c[0]  = '0;
    if (dec_launch) begin
      ctl_c[0]   = '{valid: 1'b1, cmd: CMD_ERASE, dec: 1'b1};
      key_c[0]   = ekey_q;
      k_c[0]     = '0;
      depth_c[0] = '0;
    end else begin
      ctl_c[0]   = '{valid: walk, cmd: in_i.cmd, dec: 1'b0};
      key_c[0]   = ekey;
      k_c[0]     = COUNT_BITS'(W'(in_i.rank_index));
      depth_c[0] = dclamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      size_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_q + KEY_BITS'(1);
      size_q  <= size_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    cnt_q   <= cnt_d;
    stat_q  <= stat_d;
    if (walk) begin
      ekey_q <= ekey;
    end
  end

  for (genvar g = 1; g <= KEY_BITS; g++) begin : g_cell
    btm_cell #(
      .LEVEL     (g),
      .KEY_BITS  (KEY_BITS),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clr_i     (state_q == S_CLEAR),
      .clr_addr_i(clr_q),
      .ctl_i     (ctl_c[g-1]),
      .key_i     (key_c[g-1]),
      .path_i    (path_c[g-1]),
      .k_i       (k_c[g-1]),
      .tot_i     (tot_c[g-1]),
      .depth_i   (depth_c[g-1]),
      .ctl_o     (ctl_c[g]),
      .key_o     (key_c[g]),
      .path_o    (path_c[g]),
      .k_o       (k_c[g]),
      .tot_o     (tot_c[g]),
      .depth_o   (depth_c[g])
    );
  end

  assign cnt_w  = W'(cnt_q);
  assign size_w = W'(size_q);

  assign out_o.valid       = ov_q;
  assign out_o.found_key   = found_q;
  assign out_o.count_value = cnt_w[CNT_W-1:0];
  assign out_o.set_size    = size_w[CNT_W-1:0];
  assign out_o.status      = stat_q;
endmodule

// File: tb/btm_checker.sv
// Result checker for binary_trie_multiset: tracks command and result transfers,
// keeps its own trie of occurrence counts and compares every result field.
// Depends on btm_pkg, btm_in_if and btm_out_if.
`timescale 1ns / 1ps
module btm_checker import btm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  btm_in_if    cmd_w,
  btm_out_if   res_w,
  output int   errors_o,
  output int   pending_o,
  output int   results_o
);

  localparam int unsigned KB    = KEY_BITS_DEF;
  localparam int unsigned NODES = 1 << (KB + 1);
  localparam logic [31:0] CMAX  = (1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [KB-1:0]    found;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] size;
    stat_e            st;
  } answer_t;

  logic [31:0] trie_cnt [NODES];
  answer_t     answers_q [$];

  function automatic logic [KB-1:0] nearest_xor(logic [KB-1:0] bias);
    int unsigned n;
    logic        f;
    logic [KB-1:0] r;
    n = 1;
    r = '0;
    for (int b = KB - 1; b >= 0; b--) begin
      f = bias[b];
      if (trie_cnt[(2 * n + f) % NODES] == 0) f = ~f;
      n = 2 * n + f;
      r[b] = f;
    end
    return r;
  endfunction

  function automatic logic [31:0] count_under(logic [KB-1:0] v);
    int unsigned n;
    logic [31:0] total;
    n = 1;
    total = 0;
    for (int b = KB - 1; b >= 0; b--) begin
      if (v[b]) total += trie_cnt[2 * n];
      n = 2 * n + v[b];
    end
    return total;
  endfunction

  function automatic answer_t apply_cmd(cmd_e c, logic [KB-1:0] k, logic [RANK_W-1:0] r,
                                        logic [DEPTH_W-1:0] d);
    answer_t     a;
    logic [31:0] sz, cnt, kk;
    int unsigned leaf, n, dd;
    a.found = '0;
    a.st = STAT_OK;
    cnt = 0;
    leaf = (1 << KB) | k;
    sz = trie_cnt[1];
    if (c == CMD_INSERT) begin
      if (sz >= CMAX) a.st = STAT_FULL;
      else for (int b = KB; b >= 0; b--) trie_cnt[leaf >> b]++;
    end else if (c == CMD_ERASE) begin
      if (sz == 0) a.st = STAT_EMPTY;
      else if (trie_cnt[leaf] == 0) a.st = STAT_ABSENT;
      else for (int b = KB; b >= 0; b--) trie_cnt[leaf >> b]--;
    end else if (sz == 0) begin
      a.st = STAT_EMPTY;
    end else begin
      case (c)
        CMD_XOR_MIN: a.found = nearest_xor(k);
        CMD_XOR_MAX: a.found = nearest_xor(~k);
        CMD_KTH: begin
          if (r >= sz) a.st = STAT_RANGE;
          else begin
            n = 1;
            kk = r;
            for (int b = KB - 1; b >= 0; b--) begin
              if (kk < trie_cnt[2 * n]) n = 2 * n;
              else begin
                kk -= trie_cnt[2 * n];
                n = 2 * n + 1;
                a.found[b] = 1'b1;
              end
            end
          end
        end
        CMD_CNT_BELOW:  cnt = count_under(k);
        CMD_CNT_ATMOST: cnt = (k == '1) ? sz : count_under(k + 1'b1);
        default: begin
          dd = (d > KB) ? KB : d;
          cnt = trie_cnt[((1 << dd) | (k >> (KB - dd))) % NODES];
        end
      endcase
    end
    if (a.st != STAT_OK) begin
      a.found = '0;
      cnt = 0;
    end
    a.cnt = cnt[CNT_W-1:0];
    a.size = trie_cnt[1][CNT_W-1:0];
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) trie_cnt[i] = 0;
      answers_q.delete();
      errors_o  <= 0;
      results_o <= 0;
    end else begin
      if (res_w.valid && res_w.ready) begin
        results_o <= results_o + 1;
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result found=%h cnt=%0d size=%0d st=%0d", $time,
                   res_w.found_key, res_w.count_value, res_w.set_size, res_w.status);
          errors_o <= errors_o + 1;
        end else begin
          want = answers_q.pop_front();
          if (res_w.found_key !== want.found || res_w.count_value !== want.cnt ||
              res_w.set_size !== want.size || res_w.status !== want.st) begin
            $display("%0t: mismatch exp found=%h cnt=%0d size=%0d st=%0d", $time,
                     want.found, want.cnt, want.size, want.st);
            $display("%0t:          got found=%h cnt=%0d size=%0d st=%0d", $time,
                     res_w.found_key, res_w.count_value, res_w.set_size, res_w.status);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cmd_w.valid && cmd_w.ready)
        answers_q.push_back(apply_cmd(cmd_w.cmd, cmd_w.key, cmd_w.rank_index,
                                      cmd_w.prefix_depth));
    end
  end

  assign pending_o = answers_q.size();

endmodule

// File: tb/tb.sv
// Top of the binary_trie_multiset testbench: clock, reset, command stimulus and
// result back-pressure; checking is done by btm_checker.
// Depends on btm_pkg, the channel interfaces, btm_checker and the RTL.
`timescale 1ns / 1ps
module tb;
  import btm_pkg::*;

  localparam longint LIMIT = 1_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, results;
  int   sent = 0;
  bit   gaps_on = 1'b1;
  bit   hold_req = 1'b0;
  longint cycles = 0;

  btm_in_if  cmd_ch ();
  btm_out_if res_ch ();

  binary_trie_multiset dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch), .out_o(res_ch));

  btm_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_w(cmd_ch), .res_w(res_ch),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL binary_trie_multiset");
      $finish;
    end
  end

  // result side back-pressure
  int rx_wait = 0;
  int rx_hold = 0;
  initial res_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && rx_hold == 0) rx_hold = 600;
      if (res_ch.valid && res_ch.ready)
        rx_wait = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, 17) : 0;
      else if (rx_wait > 0) rx_wait--;
      if (rx_hold > 0) rx_hold--;
      res_ch.ready <= (rx_wait == 0 && rx_hold == 0);
    end
  end

  task automatic send(cmd_e c, logic [11:0] k, logic [15:0] r, logic [3:0] d);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.cmd          <= c;
    cmd_ch.key          <= k;
    cmd_ch.rank_index   <= r;
    cmd_ch.prefix_depth <= d;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic random_cmd();
    int   p;
    cmd_e c;
    logic [11:0] k;
    p = $urandom_range(0, 99);
    if (p < 35) c = CMD_INSERT;
    else if (p < 55) c = CMD_ERASE;
    else c = cmd_e'($urandom_range(2, 7));
    k = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 47) * 85);
    send(c, k, ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)),
         4'($urandom_range(0, 15)));
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_INSERT;
    cmd_ch.key = '0;
    cmd_ch.rank_index = '0;
    cmd_ch.prefix_depth = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty set, boundaries, every command
    for (int c = 1; c < 8; c++) send(cmd_e'(c), 12'hfff, 16'h0, 4'd3);
    send(CMD_INSERT, 12'h000, 0, 0);
    send(CMD_INSERT, 12'hfff, 0, 0);
    send(CMD_INSERT, 12'hfff, 0, 0);
    send(CMD_ERASE, 12'h5a5, 0, 0);
    send(CMD_XOR_MIN, 12'h000, 0, 0);
    send(CMD_XOR_MIN, 12'hfff, 0, 0);
    send(CMD_XOR_MAX, 12'h000, 0, 0);
    send(CMD_XOR_MAX, 12'h800, 0, 0);
    send(CMD_KTH, 0, 16'd0, 0);
    send(CMD_KTH, 0, 16'd2, 0);
    send(CMD_KTH, 0, 16'd3, 0);
    send(CMD_KTH, 0, 16'hffff, 0);
    send(CMD_CNT_BELOW, 12'h000, 0, 0);
    send(CMD_CNT_BELOW, 12'hfff, 0, 0);
    send(CMD_CNT_ATMOST, 12'hfff, 0, 0);
    send(CMD_CNT_ATMOST, 12'hffe, 0, 0);
    send(CMD_PREFIX, 12'hfff, 0, 4'd0);
    send(CMD_PREFIX, 12'hfff, 0, 4'd12);
    send(CMD_PREFIX, 12'hf00, 0, 4'd15);
    send(CMD_ERASE, 12'hfff, 0, 0);

    for (int i = 0; i < 1600; i++) begin
      if (i == 400) hold_req = 1'b1;
      if (i == 420) hold_req = 1'b0;
      if (i % 300 == 250) gaps_on = ~gaps_on;
      random_cmd();
    end

    // closing checks back to back
    gaps_on = 1'b0;
    send(CMD_PREFIX, 12'h0a5, 0, 4'd12);
    send(CMD_KTH, 0, 16'hfffe, 0);
    send(CMD_CNT_ATMOST, 12'hfff, 0, 0);
    send(CMD_ERASE, 12'h0a5, 0, 0);
    send(CMD_INSERT, 12'h3c3, 0, 0);
    send(CMD_INSERT, 12'h3c3, 0, 0);
    send(CMD_XOR_MAX, 12'h3c3, 0, 0);
    cmd_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    $display("sent %0d commands, %0d results checked, including a long result stall", sent,
             results);
    $display("and the empty-set and boundary cases of every command");
    if (errors == 0 && pending == 0) begin
      $display("PASS binary_trie_multiset");
    end else begin
      $display("FAIL binary_trie_multiset");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/btm_pkg.sv
sv/btm_in_if.sv
sv/btm_out_if.sv
sv/btm_ram.sv
sv/btm_cell.sv
sv/binary_trie_multiset.sv
tb/btm_checker.sv
tb/tb.sv
